// ----- rtl/i2rn_pkg.sv -----
// ----------------------------------------------------------------------------
// i2rn_pkg
// Shared types, codes and letter tables for the integer to roman numeral block.
// ----------------------------------------------------------------------------
package i2rn_pkg;

  localparam int VALUE_W = 12;
  localparam int LETTER_W = 8;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

  // reciprocal multipliers: v/100 = (v*5243)>>19, v/10 = (v*6554)>>16, n/10 = (n*205)>>11
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [12:0] RECIP_10_WIDE = 13'd6554;
  localparam logic [7:0]  RECIP_10 = 8'd205;

  // ascii letters
  localparam logic [LETTER_W-1:0] CH_M = 8'h4D;
  localparam logic [LETTER_W-1:0] CH_D = 8'h44;
  localparam logic [LETTER_W-1:0] CH_C = 8'h43;
  localparam logic [LETTER_W-1:0] CH_L = 8'h4C;
  localparam logic [LETTER_W-1:0] CH_X = 8'h58;
  localparam logic [LETTER_W-1:0] CH_V = 8'h56;
  localparam logic [LETTER_W-1:0] CH_I = 8'h49;
  localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;

  // digit places, most significant first
  localparam logic [1:0] PL_THOU = 2'd0;
  localparam logic [1:0] PL_HUND = 2'd1;
  localparam logic [1:0] PL_TENS = 2'd2;
  localparam logic [1:0] PL_UNIT = 2'd3;

  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SPLIT = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

  typedef struct packed {
    logic load;      // capture the input word
    logic split;     // break the value into decimal digits
    logic emit;      // put the next letter into the output register
    logic emit_bad;  // put the out-of-range word into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic bad;       // captured value is 0 or 4000 and up
    logic last;      // the letter at the sequencer is the final one
    logic out_free;  // output register can take a word this cycle
  } dp_sts_t;

  // letters spent on one decimal digit (hundreds, tens, units)
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] len;
    case (d)
      4'd1, 4'd5: len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
      4'd3, 4'd7: len = 3'd3;
      4'd8: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // thousands are plain repeats of M
  function automatic logic [2:0] place_len(input logic [1:0] pl, input logic [3:0] d);
    logic [2:0] len;
    if (pl == PL_THOU) len = d[2:0];
    else len = digit_len(d);
    return len;
  endfunction

  function automatic sym_t digit_sym(input logic [3:0] d, input logic [1:0] k);
    sym_t s;
    s = SYM_ONE;
    if (k == 2'd0) begin
      if (d >= 4'd5 && d <= 4'd8) s = SYM_FIVE;
    end else if (k == 2'd1) begin
      if (d == 4'd4) s = SYM_FIVE;
      else if (d == 4'd9) s = SYM_TEN;
    end
    return s;
  endfunction

  function automatic logic [LETTER_W-1:0] place_letter(input logic [1:0] pl, input sym_t s);
    logic [LETTER_W-1:0] ch;
    ch = CH_M;
    case (pl)
      PL_HUND: begin
        case (s)
          SYM_ONE:  ch = CH_C;
          SYM_FIVE: ch = CH_D;
          default:  ch = CH_M;
        endcase
      end
      PL_TENS: begin
        case (s)
          SYM_ONE:  ch = CH_X;
          SYM_FIVE: ch = CH_L;
          default:  ch = CH_C;
        endcase
      end
      PL_UNIT: begin
        case (s)
          SYM_ONE:  ch = CH_I;
          SYM_FIVE: ch = CH_V;
          default:  ch = CH_X;
        endcase
      end
      default: ch = CH_M;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/i2rn_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2rn_ctrl
// Sequencing state machine: capture, digit split, then one letter per word.
// ----------------------------------------------------------------------------
module i2rn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output i2rn_pkg::dp_cmd_t cmd,
  input  i2rn_pkg::dp_sts_t sts
);
  import i2rn_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (sts.bad) begin
          if (sts.out_free) begin
            cmd.emit_bad = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.split = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/i2rn_dp.sv -----
// ----------------------------------------------------------------------------
// i2rn_dp
// Datapath: reciprocal digit split, letter sequencer and output register.
// ----------------------------------------------------------------------------
module i2rn_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [i2rn_pkg::VALUE_W-1:0]  in_value,
  input  i2rn_pkg::dp_cmd_t             cmd,
  output i2rn_pkg::dp_sts_t             sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [i2rn_pkg::LETTER_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);
  import i2rn_pkg::*;

  // captured value and its coarse quotients
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [5:0]          hq_r, hq_nxt;     // value / 100
  logic [8:0]          tq_r, tq_nxt;     // value / 10
  logic                bad_r, bad_nxt;

  // digits and sequencer position
  logic [3:0]          dig_r [4];
  logic [3:0]          dig_nxt [4];
  logic [1:0]          place_r, place_nxt;
  logic [1:0]          k_r, k_nxt;

  // output register
  logic                ovalid_r, ovalid_nxt;
  logic [LETTER_W-1:0] oletter_r, oletter_nxt;
  logic                olast_r, olast_nxt;
  logic                oinv_r, oinv_nxt;

  logic [24:0]         h_prod, t_prod;
  logic [13:0]         th_prod;
  logic [16:0]         q_prod;
  logic [2:0]          th;
  logic [5:0]          q;
  logic [5:0]          th_x10, hun_full;
  logic [8:0]          q_x10, ten_full;
  logic [11:0]         t_x10, unit_full;
  logic [3:0]          split_dig [4];
  logic [1:0]          first_pl;

  logic [3:0]          cur_d;
  logic [2:0]          cur_len;
  logic                k_end;
  logic                more;
  logic [1:0]          next_pl;
  logic                out_free;

  always_comb begin
    h_prod = 25'(in_value) * 25'(RECIP_100);
    t_prod = 25'(in_value) * 25'(RECIP_10_WIDE);

    // second level split of the captured quotients
    th_prod = 14'(hq_r) * 14'(RECIP_10);
    th = th_prod[13:11];
    th_x10 = 6'({th, 3'b000}) + 6'({th, 1'b0});
    hun_full = hq_r - th_x10;
    q_prod = 17'(tq_r) * 17'(RECIP_10);
    q = q_prod[16:11];
    q_x10 = 9'({q, 3'b000}) + 9'({q, 1'b0});
    ten_full = tq_r - q_x10;
    t_x10 = 12'({tq_r, 3'b000}) + 12'({tq_r, 1'b0});
    unit_full = value_r - t_x10;
    split_dig[0] = {1'b0, th};
    split_dig[1] = hun_full[3:0];
    split_dig[2] = ten_full[3:0];
    split_dig[3] = unit_full[3:0];

    // first place that has any letters
    first_pl = PL_UNIT;
    for (int p = 3; p >= 0; p--) begin
      if (place_len(p[1:0], split_dig[p]) != 3'd0) first_pl = p[1:0];
    end

    cur_d = dig_r[place_r];
    cur_len = place_len(place_r, cur_d);
    k_end = (({1'b0, k_r} + 3'd1) == cur_len);

    // nearest later place that still has letters
    more = 1'b0;
    next_pl = place_r;
    for (int p = 3; p >= 0; p--) begin
      if (p[1:0] > place_r && place_len(p[1:0], dig_r[p]) != 3'd0) begin
        more = 1'b1;
        next_pl = p[1:0];
      end
    end

    out_free = !ovalid_r || out_tready;
    sts.bad = bad_r;
    sts.last = k_end && !more;
    sts.out_free = out_free;
  end

  always_comb begin
    value_nxt = value_r;
    hq_nxt = hq_r;
    tq_nxt = tq_r;
    bad_nxt = bad_r;
    dig_nxt = dig_r;
    place_nxt = place_r;
    k_nxt = k_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oletter_nxt = oletter_r;
    olast_nxt = olast_r;
    oinv_nxt = oinv_r;

    if (cmd.load) begin
      value_nxt = in_value;
      hq_nxt = h_prod[24:19];
      tq_nxt = t_prod[24:16];
      bad_nxt = (in_value == '0) || (in_value >= VALUE_LIMIT);
    end

    if (cmd.split) begin
      dig_nxt = split_dig;
      place_nxt = first_pl;
      k_nxt = 2'd0;
    end

    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      oletter_nxt = place_letter(place_r, digit_sym(cur_d, k_r));
      olast_nxt = k_end && !more;
      oinv_nxt = 1'b0;
      if (k_end) begin
        place_nxt = next_pl;
        k_nxt = 2'd0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end

    if (cmd.emit_bad) begin
      ovalid_nxt = 1'b1;
      oletter_nxt = CH_NONE;
      olast_nxt = 1'b1;
      oinv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    hq_r <= hq_nxt;
    tq_r <= tq_nxt;
    bad_r <= bad_nxt;
    dig_r <= dig_nxt;
    place_r <= place_nxt;
    k_r <= k_nxt;
    oletter_r <= oletter_nxt;
    olast_r <= olast_nxt;
    oinv_r <= oinv_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = oletter_r;
  assign out_tlast = olast_r;
  assign out_tuser = oinv_r;

endmodule

// ----- rtl/integer_to_roman_numeral.sv -----
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a whole number to its roman numeral, one ascii letter per word.
//
//   channel   dir  tdata                         tlast        tuser
//   in_       in   [11:0] value, [15:12] zero    -            -
//   out_      out  [7:0] letter                  is_last      invalid
//
// An item runs through capture and digit split, then up to 15 letters (3888
// has the most) at one a cycle while the output is not stalled. An out-of-range
// value is captured and yields one word. The letter sequencer sets the rate.
// in_tready is high only while no item is in work; the output register
// holds a word while out_tready is low and stalls the sequencer.
// rst_n is synchronous and clears the state machine and output valid.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] value, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] letter
  output logic        out_tlast,
  output logic        out_tuser   // [0] invalid
);
  import i2rn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  i2rn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  i2rn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams numbers into the roman numeral converter and checks every letter
// word against a local prediction. It runs directed corner values first and
// then random values over three backpressure phases.
// ----------------------------------------------------------------------------
module testbench;
  import i2rn_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int REPORT_MAX = 10;

  // letters for one/five/ten at the hundreds, tens and units places
  localparam logic [7:0] DIGIT_CH [3][3] = '{
    '{CH_C, CH_D, CH_M},
    '{CH_X, CH_L, CH_C},
    '{CH_I, CH_V, CH_X}
  };

  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       bad;
  } numeral_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  logic [11:0]   value_q [$];
  numeral_word_t numeral_q [$];
  logic          in_fire;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches;
  int            values_sent;
  int            bad_values_sent;
  int            words_seen;
  int            stall_cycles;

  integer_to_roman_numeral i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void push_letter(input logic [7:0] ch);
    numeral_q.push_back('{letter: ch, last: 1'b0, bad: 1'b0});
  endfunction

  // expected letter words for one value, most significant place first
  function automatic void predict_numeral(input logic [11:0] v);
    int unsigned digit [3];
    int unsigned n;
    int unsigned d;
    if (v == 12'd0 || v >= 12'd4000) begin
      numeral_q.push_back('{letter: CH_NONE, last: 1'b1, bad: 1'b1});
      return;
    end
    for (n = 0; n < v / 1000; n++) push_letter(CH_M);
    digit[0] = (v / 100) % 10;
    digit[1] = (v / 10) % 10;
    digit[2] = v % 10;
    for (int p = 0; p < 3; p++) begin
      d = digit[p];
      case (d)
        4: begin
          push_letter(DIGIT_CH[p][SYM_ONE]);
          push_letter(DIGIT_CH[p][SYM_FIVE]);
        end
        9: begin
          push_letter(DIGIT_CH[p][SYM_ONE]);
          push_letter(DIGIT_CH[p][SYM_TEN]);
        end
        default: begin
          if (d >= 5) begin
            push_letter(DIGIT_CH[p][SYM_FIVE]);
            d = d - 5;
          end
          for (n = 0; n < d; n++) push_letter(DIGIT_CH[p][SYM_ONE]);
        end
      endcase
    end
    numeral_q[numeral_q.size()-1].last = 1'b1;
  endfunction

  // driver: valid stays up until the word is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (!in_tvalid || in_fire) begin
        if (value_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {4'd0, value_q.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: predicts on input words, checks output words
  always @(posedge clk) begin
    numeral_word_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (in_tvalid && in_tready) begin
        predict_numeral(in_tdata[11:0]);
        values_sent++;
        if (in_tdata[11:0] == 12'd0 || in_tdata[11:0] >= 12'd4000) bad_values_sent++;
      end
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (numeral_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected word: letter %h last %b invalid %b",
                     out_tdata, out_tlast, out_tuser);
        end else begin
          want = numeral_q.pop_front();
          if (out_tdata !== want.letter || out_tlast !== want.last ||
              out_tuser !== want.bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("word %0d mismatch: expected letter %h last %b invalid %b, got %h %b %b",
                       words_seen, want.letter, want.last, want.bad,
                       out_tdata, out_tlast, out_tuser);
          end
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [11:0] corner_values [];
    logic [11:0] v;
    corner_values = '{
      12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
      12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd6, 12'd7, 12'd8,
      12'd1000, 12'd2000, 12'd3000, 12'd444, 12'd999, 12'd1994, 12'd2048
    };
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    in_fire = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    values_sent = 0;
    bad_values_sent = 0;
    words_seen = 0;
    stall_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 67;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_values[i]) value_q.push_back(corner_values[i]);
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // mostly valid numbers, one in eight out of range
        if ($urandom_range(7, 0) != 0) v = 12'($urandom_range(3999, 1));
        else if ($urandom_range(3, 0) == 0) v = 12'd0;
        else v = 12'($urandom_range(4095, 4000));
        value_q.push_back(v);
      end
      // hold off the next phase until every letter is out
      do @(negedge clk);
      while (value_q.size() != 0 || in_tvalid || numeral_q.size() != 0);
      @(posedge clk);
      if (phase == 0) begin
        send_idle_pct = 67;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    repeat (40) @(negedge clk);
    $display("converted %0d values (%0d out of range) into %0d letter words",
             values_sent, bad_values_sent, words_seen);
    $display("backpressure phases: slow sink, slow source, full rate");
    if (mismatches == 0 && numeral_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, numeral_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/i2rn_pkg.sv
rtl/i2rn_ctrl.sv
rtl/i2rn_dp.sv
rtl/integer_to_roman_numeral.sv
tb/sv/testbench.sv
